// ===== sv/swmed_pkg.sv =====
// Shared types and constants for the sliding window median filter.
// No dependencies; used by the cell row, the top level and the testbench.
package swmed_pkg;

   // Width of the window length register.
   localparam int CFG_W = 7;

   // Per-transfer broadcast from the top level to every cell.
   typedef struct packed {
      logic accept;   // a sample is taken this cycle
      logic evict;    // the oldest entry leaves in the same cycle
   } swmed_ctl_type;

endpackage

// ===== sv/swmed_cell.sv =====
// One slot of the sorted window: holds a sample and its age.
// Depends on swmed_pkg; exchanges data with both neighbors every cycle.
module swmed_cell #(
   parameter int CELL_IDX    = 0,
   parameter int SAMPLE_BITS = 32,
   parameter int AGE_W       = 6,
   parameter int CMP_W       = 7
) (
   input  logic                          clock,
   input  swmed_pkg::swmed_ctl_type      ctl,
   input  logic signed [SAMPLE_BITS-1:0] key,
   input  logic [CMP_W-1:0]              fill,
   input  logic [CMP_W-1:0]              med_idx,
   input  logic [AGE_W-1:0]              evict_age,
   input  logic signed [SAMPLE_BITS-1:0] ev_value,
   input  logic [AGE_W-1:0]              ev_age,
   // stored entry of the left neighbor
   input  logic                          lft_valid,
   input  logic                          lft_gt,
   input  logic signed [SAMPLE_BITS-1:0] lft_value,
   // stored entry of the right neighbor
   input  logic                          rgt_valid,
   input  logic                          rgt_gt,
   input  logic signed [SAMPLE_BITS-1:0] rgt_value,
   input  logic [AGE_W-1:0]              rgt_age,
   // left neighbor after removal of the evicted entry
   input  logic                          lft_cvalid,
   input  logic                          lft_cgt,
   input  logic signed [SAMPLE_BITS-1:0] lft_cvalue,
   input  logic [AGE_W-1:0]              lft_cage,
   // own stored entry
   output logic                          valid,
   output logic                          gt,
   output logic signed [SAMPLE_BITS-1:0] value,
   output logic [AGE_W-1:0]              age,
   // own slot after removal of the evicted entry
   output logic                          cvalid,
   output logic                          cgt,
   output logic signed [SAMPLE_BITS-1:0] cvalue,
   output logic [AGE_W-1:0]              cage,
   output logic                          ev_hit,
   output logic signed [SAMPLE_BITS-1:0] med_value
);

   localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(CELL_IDX);

   logic signed [SAMPLE_BITS-1:0] value_ff, value_in;
   logic [AGE_W-1:0]              age_ff, age_in;
   logic                          right_of_ev;
   logic                          shift_left;
   logic                          take_left;
   logic                          take_key;
   logic signed [SAMPLE_BITS-1:0] med_cand;

   assign value = value_ff;
   assign age   = age_ff;
   assign valid = (MY_IDX < fill);
   assign gt    = valid && (value_ff > key);

   // Entries are ordered by value, then oldest first among equals.
   assign ev_hit      = ctl.evict && valid && (age_ff == evict_age);
   assign right_of_ev = valid && ((value_ff > ev_value) ||
                                  ((value_ff == ev_value) && (age_ff < ev_age)));
   assign shift_left  = ctl.evict && (right_of_ev || ev_hit);

   assign cvalid = shift_left ? rgt_valid : valid;
   assign cgt    = shift_left ? rgt_gt    : gt;
   assign cvalue = shift_left ? rgt_value : value_ff;
   assign cage   = shift_left ? rgt_age   : age_ff;

   // Insert the new sample into the compacted row.
   assign take_left = lft_cgt;
   assign take_key  = !lft_cgt && lft_cvalid && (cgt || !cvalid);

   always_comb begin
      if (take_left) begin
         value_in = lft_cvalue;
         age_in   = lft_cage + AGE_W'(1);
      end else if (take_key) begin
         value_in = key;
         age_in   = '0;
      end else begin
         value_in = cvalue;
         age_in   = cage + AGE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

   // What this slot would hold after insertion alone, before eviction.
   always_comb begin
      if (lft_gt) begin
         med_cand = lft_value;
      end else if (lft_valid && (gt || !valid)) begin
         med_cand = key;
      end else begin
         med_cand = value_ff;
      end
   end

   assign med_value = (MY_IDX == med_idx) ? med_cand : '0;

endmodule

// ===== sv/swmed_out_buf.sv =====
// Result register with one skid entry, so a new sample can be taken
// while a finished result waits. Depends on nothing else.
module swmed_out_buf #(
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              out_stall,
   output logic              out_valid,
   output logic [DATA_W-1:0] out_data,
   output logic              full
);

   logic              main_valid_ff, main_valid_in;
   logic [DATA_W-1:0] main_data_ff, main_data_in;
   logic              skid_valid_ff, skid_valid_in;
   logic [DATA_W-1:0] skid_data_ff, skid_data_in;
   logic              main_free;

   assign main_free = !main_valid_ff || !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;
   assign full      = skid_valid_ff;

endmodule

// ===== sv/sliding_window_median.sv =====
// Channel   Ports                          Direction
// input     req_valid req_stall req_sample  sample in
// result    rsp_valid rsp_stall rsp_median  lower median out
// config    csr_wr_en csr_wr_data           window length write
//
// One sample per cycle while req_stall is low: every cell of the sorted row updates
// from its neighbors in the transfer cycle, and once the window is full the median
// is registered into the result register, or into its skid entry while a result waits.
// Reset empties the window and sets the window length to 1.
// req_stall rises only when the result register and its skid entry both hold.
// Top level of the sliding window median; uses swmed_pkg, swmed_cell,
// swmed_out_buf.
module sliding_window_median #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]       rsp_median,
   input  logic                                csr_wr_en,
   input  logic [swmed_pkg::CFG_W-1:0]         csr_wr_data
);

   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CMP_W = (CNT_W > swmed_pkg::CFG_W) ? CNT_W : swmed_pkg::CFG_W;

   logic [swmed_pkg::CFG_W-1:0] wlen_ff, wlen_in;
   logic [CNT_W-1:0]            fill_ff, fill_in;

   logic                     accept;
   logic [CMP_W-1:0]         wlen_ext;
   logic [CMP_W-1:0]         fill_ext;
   logic [CMP_W-1:0]         med_idx;
   logic [AGE_W-1:0]         evict_age;
   logic                     window_full;
   swmed_pkg::swmed_ctl_type ctl;

   logic signed [SAMPLE_BITS-1:0] ev_value;
   logic [AGE_W-1:0]              ev_age;
   logic signed [SAMPLE_BITS-1:0] median;

   logic                          c_valid  [WINDOW_MAX];
   logic                          c_gt     [WINDOW_MAX];
   logic signed [SAMPLE_BITS-1:0] c_value  [WINDOW_MAX];
   logic [AGE_W-1:0]              c_age    [WINDOW_MAX];
   logic                          c_cvalid [WINDOW_MAX];
   logic                          c_cgt    [WINDOW_MAX];
   logic signed [SAMPLE_BITS-1:0] c_cvalue [WINDOW_MAX];
   logic [AGE_W-1:0]              c_cage   [WINDOW_MAX];
   logic                          c_ev_hit [WINDOW_MAX];
   logic signed [SAMPLE_BITS-1:0] c_med    [WINDOW_MAX];

   logic out_full;

   assign accept   = req_valid && !req_stall;
   assign wlen_ext = CMP_W'(wlen_ff);
   assign fill_ext = CMP_W'(fill_ff);
   assign med_idx  = (wlen_ext - CMP_W'(1)) >> 1;
   // oldest entry before the age bump; only used when the window is 2 or more
   assign evict_age   = AGE_W'(wlen_ext - CMP_W'(2));
   assign window_full = (fill_ext == wlen_ext - CMP_W'(1));

   assign ctl.accept = accept;
   assign ctl.evict  = accept && window_full && (wlen_ext > CMP_W'(1));

   // Window length write: zero reads as one, large values saturate.
   always_comb begin
      wlen_in = wlen_ff;
      fill_in = fill_ff;
      if (csr_wr_en) begin
         fill_in = '0;
         if (csr_wr_data == '0) begin
            wlen_in = swmed_pkg::CFG_W'(1);
         end else if (CMP_W'(csr_wr_data) > CMP_W'(WINDOW_MAX)) begin
            wlen_in = swmed_pkg::CFG_W'(WINDOW_MAX);
         end else begin
            wlen_in = csr_wr_data;
         end
      end else if (accept && !window_full) begin
         fill_in = fill_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= swmed_pkg::CFG_W'(1);
         fill_ff <= '0;
      end else begin
         wlen_ff <= wlen_in;
         fill_ff <= fill_in;
      end
   end

   // Broadcast the evicted entry and gather the median; one-hot AND-OR.
   always_comb begin
      ev_value = '0;
      ev_age   = '0;
      median   = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         if (c_ev_hit[i]) begin
            ev_value = ev_value | c_value[i];
            ev_age   = ev_age | c_age[i];
         end
         median = median | c_med[i];
      end
   end

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic                          lft_valid, lft_gt, lft_cvalid, lft_cgt;
      logic signed [SAMPLE_BITS-1:0] lft_value, lft_cvalue;
      logic [AGE_W-1:0]              lft_cage;
      logic                          rgt_valid, rgt_gt;
      logic signed [SAMPLE_BITS-1:0] rgt_value;
      logic [AGE_W-1:0]              rgt_age;

      if (i == 0) begin : g_head
         // left edge: insertion may always land in the first slot
         assign lft_valid  = 1'b1;
         assign lft_gt     = 1'b0;
         assign lft_value  = '0;
         assign lft_cvalid = 1'b1;
         assign lft_cgt    = 1'b0;
         assign lft_cvalue = '0;
         assign lft_cage   = '0;
      end else begin : g_link_l
         assign lft_valid  = c_valid[i-1];
         assign lft_gt     = c_gt[i-1];
         assign lft_value  = c_value[i-1];
         assign lft_cvalid = c_cvalid[i-1];
         assign lft_cgt    = c_cgt[i-1];
         assign lft_cvalue = c_cvalue[i-1];
         assign lft_cage   = c_cage[i-1];
      end

      if (i == WINDOW_MAX - 1) begin : g_tail
         assign rgt_valid = 1'b0;
         assign rgt_gt    = 1'b0;
         assign rgt_value = '0;
         assign rgt_age   = '0;
      end else begin : g_link_r
         assign rgt_valid = c_valid[i+1];
         assign rgt_gt    = c_gt[i+1];
         assign rgt_value = c_value[i+1];
         assign rgt_age   = c_age[i+1];
      end

      swmed_cell #(
         .CELL_IDX    (i),
         .SAMPLE_BITS (SAMPLE_BITS),
         .AGE_W       (AGE_W),
         .CMP_W       (CMP_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .key        (req_sample),
         .fill       (fill_ext),
         .med_idx    (med_idx),
         .evict_age  (evict_age),
         .ev_value   (ev_value),
         .ev_age     (ev_age),
         .lft_valid  (lft_valid),
         .lft_gt     (lft_gt),
         .lft_value  (lft_value),
         .rgt_valid  (rgt_valid),
         .rgt_gt     (rgt_gt),
         .rgt_value  (rgt_value),
         .rgt_age    (rgt_age),
         .lft_cvalid (lft_cvalid),
         .lft_cgt    (lft_cgt),
         .lft_cvalue (lft_cvalue),
         .lft_cage   (lft_cage),
         .valid      (c_valid[i]),
         .gt         (c_gt[i]),
         .value      (c_value[i]),
         .age        (c_age[i]),
         .cvalid     (c_cvalid[i]),
         .cgt        (c_cgt[i]),
         .cvalue     (c_cvalue[i]),
         .cage       (c_cage[i]),
         .ev_hit     (c_ev_hit[i]),
         .med_value  (c_med[i])
      );
   end

   swmed_out_buf #(
      .DATA_W (SAMPLE_BITS)
   ) u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && window_full),
      .push_data (median),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_median),
      .full      (out_full)
   );

   assign req_stall = out_full;

endmodule

// ===== dv/sliding_window_median_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sliding_window_median: a directed table, then random
// phases over several window lengths, with a running median predictor. Depends on swmed_pkg.
module sliding_window_median_tb;

   localparam int WINDOW_MAX  = 64;
   localparam int SAMPLE_BITS = 32;
   localparam int CFG_W       = swmed_pkg::CFG_W;
   localparam int DRAIN_LIMIT = 5000;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef enum logic {ROW_CSR, ROW_SAMPLE} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      sample_type   value;    // sample, or raw window length for ROW_CSR
      logic         pinned;   // expected median typed in below
      sample_type   pin;
   } stim_row_type;

   localparam sample_type S_MAX = 32'sh7FFF_FFFF;
   localparam sample_type S_MIN = 32'sh8000_0000;

   // Window 1 after reset: each sample is its own median.
   stim_row_type directed_rows [21] = '{
      '{ROW_SAMPLE, 32'sd0,  1'b1, 32'sd0},
      '{ROW_SAMPLE, S_MAX,   1'b1, S_MAX},
      '{ROW_SAMPLE, S_MIN,   1'b1, S_MIN},
      '{ROW_SAMPLE, -32'sd1, 1'b1, -32'sd1},
      '{ROW_CSR,    32'sd0,  1'b0, 32'sd0},    // zero length stored as 1
      '{ROW_SAMPLE, 32'sd5,  1'b1, 32'sd5},
      '{ROW_CSR,    32'sd2,  1'b0, 32'sd0},    // even window: smaller middle
      '{ROW_SAMPLE, 32'sd10, 1'b0, 32'sd0},
      '{ROW_SAMPLE, -32'sd3, 1'b1, -32'sd3},
      '{ROW_SAMPLE, S_MIN,   1'b1, S_MIN},
      '{ROW_CSR,    32'sd3,  1'b0, 32'sd0},
      '{ROW_SAMPLE, 32'sd7,  1'b0, 32'sd0},    // equal samples
      '{ROW_SAMPLE, 32'sd7,  1'b0, 32'sd0},
      '{ROW_SAMPLE, 32'sd7,  1'b1, 32'sd7},
      '{ROW_SAMPLE, S_MAX,   1'b0, 32'sd0},
      '{ROW_SAMPLE, 32'sd1,  1'b0, 32'sd0},
      '{ROW_CSR,    32'sd4,  1'b0, 32'sd0},    // length change mid-stream empties window
      '{ROW_SAMPLE, 32'sd3,  1'b0, 32'sd0},
      '{ROW_SAMPLE, -32'sd5, 1'b0, 32'sd0},
      '{ROW_SAMPLE, 32'sd3,  1'b0, 32'sd0},
      '{ROW_SAMPLE, 32'sd9,  1'b0, 32'sd0}
   };

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   sample_type       req_sample;
   logic             rsp_valid;
   logic             rsp_stall;
   sample_type       rsp_median;
   logic             csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;

   // predictor state
   sample_type  win_vals [WINDOW_MAX];
   logic [5:0]  win_age  [WINDOW_MAX];
   int unsigned win_fill;
   int unsigned win_len;

   sample_type median_q [$];
   int         error_count;
   int         send_gap_pct;
   int         recv_stall_pct;
   int         hold_len;
   bit         pin_on;
   sample_type pin_val;

   sliding_window_median dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_median  (rsp_median),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic flag_error(input string msg);
      $display("[%0t] ERROR: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic void load_window_len(input logic [CFG_W-1:0] raw);
      int unsigned v;
      v = raw;
      if (v == 0)
         v = 1;
      if (v > WINDOW_MAX)
         v = WINDOW_MAX;
      win_len  = v;
      win_fill = 0;
   endfunction

   // Insert one sample, age the rest; once full, give the lower median and drop the oldest.
   function automatic bit median_step(input sample_type s, output sample_type med);
      int unsigned i;
      int unsigned pos;
      int unsigned oldest;
      med = '0;
      for (i = 0; i < win_fill; i++)
         win_age[i] = win_age[i] + 6'd1;
      pos = 0;
      while (pos < win_fill && win_vals[pos] <= s)
         pos++;
      for (i = win_fill; i > pos; i--) begin
         win_vals[i] = win_vals[i-1];
         win_age[i]  = win_age[i-1];
      end
      win_vals[pos] = s;
      win_age[pos]  = '0;
      win_fill++;
      if (win_fill < win_len)
         return 1'b0;
      med = win_vals[(win_fill - 1) / 2];
      oldest = 0;
      for (i = 1; i < win_fill; i++)
         if (win_age[i] > win_age[oldest])
            oldest = i;
      for (i = oldest; i + 1 < win_fill; i++) begin
         win_vals[i] = win_vals[i+1];
         win_age[i]  = win_age[i+1];
      end
      win_fill--;
      return 1'b1;
   endfunction

   always @(posedge clock) begin : monitor
      sample_type med;
      sample_type want;
      bit         got;
      if (!reset) begin
         if (req_valid && req_stall === 1'b0) begin
            got = median_step(req_sample, med);
            if (got)
               median_q.push_back(pin_on ? pin_val : med);
         end
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            if (median_q.size() == 0) begin
               flag_error($sformatf("unexpected median %0d", rsp_median));
            end else begin
               want = median_q.pop_front();
               if (rsp_median !== want)
                  flag_error($sformatf("median got %0d expected %0d", rsp_median, want));
            end
         end
      end
   end

   // Result side: random stall, or a long hold-off when requested.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_len > 0) begin
            rsp_stall <= 1'b1;
            hold_len--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
         end
      end
   end

   task automatic push_sample(input sample_type s, input bit pinned, input sample_type pin);
      if ($urandom_range(0, 99) < send_gap_pct) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      req_sample <= s;
      pin_on  = pinned;
      pin_val = pin;
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
   endtask

   // Stop offering and wait until every expected median has come out.
   task automatic drain;
      int n;
      n = 0;
      @(negedge clock) req_valid <= 1'b0;
      while (median_q.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      if (median_q.size() != 0) begin
         flag_error($sformatf("%0d medians never arrived", median_q.size()));
         median_q.delete();
      end
   endtask

   task automatic write_window(input logic [CFG_W-1:0] raw);
      drain();
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= raw;
      @(posedge clock);
      load_window_len(raw);
      @(negedge clock) csr_wr_en <= 1'b0;
   endtask

   function automatic sample_type rand_sample;
      case ($urandom_range(0, 9))
         0:       return S_MIN;
         1:       return S_MAX;
         2, 3, 4,
         5:       return sample_type'($urandom_range(0, 15)) - 32'sd8;  // forces ties
         default: return sample_type'($urandom());
      endcase
   endfunction

   initial begin : stimulus
      int             ph;
      int             seg;
      int             i;
      int             n_items;
      logic [CFG_W-1:0] raw;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_sample     = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      error_count    = 0;
      hold_len       = 0;
      pin_on         = 1'b0;
      pin_val        = '0;
      send_gap_pct   = 19;
      recv_stall_pct = 50;
      win_fill       = 0;
      win_len        = 1;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR)
            write_window(directed_rows[r].value[CFG_W-1:0]);
         else
            push_sample(directed_rows[r].value, directed_rows[r].pinned, directed_rows[r].pin);
      end

      for (ph = 0; ph < 3; ph++) begin
         case (ph)
            0:       begin send_gap_pct = 19; recv_stall_pct = 50; end
            1:       begin send_gap_pct = 50; recv_stall_pct = 19; end
            default: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
         endcase
         for (seg = 0; seg < 6; seg++) begin
            if (seg == 0) begin
               // full-size window, reached by saturation and by the exact maximum
               case (ph)
                  0:       raw = CFG_W'($urandom_range(WINDOW_MAX + 1, 127));
                  1:       raw = '1;
                  default: raw = CFG_W'(WINDOW_MAX);
               endcase
               n_items = 105;
            end else begin
               raw = CFG_W'($urandom_range(0, 9));
               n_items = 36;
            end
            if (ph == 2 && seg == 1)
               raw = CFG_W'(1);
            write_window(raw);
            // long result hold-off so the block backs up and stalls its input
            if (ph == 2 && seg == 1)
               hold_len = 300;
            for (i = 0; i < n_items; i++)
               push_sample(rand_sample(), 1'b0, '0);
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
